### rtl/core/frl_pkg.sv
// Shared constants and the square-root stage record for the Fresnel reflectance block.
// Depends on nothing; imported by frl_sqrt and fresnel_reflectance_top.
`default_nettype none
package frl_pkg;

  localparam int COMP_W    = 16;  // vector component width, Q1.15
  localparam int IOR_W     = 15;  // index register width, Q2.13
  localparam int SQ_STEPS  = 31;  // result bits of the square root
  localparam int DIV_STEPS = 30;  // quotient bits of sin_t
  localparam int RAT_STEPS = 16;  // quotient bits of each ratio

  localparam logic [IOR_W-1:0] ETA_ONE   = 15'd8192;
  localparam logic [IOR_W-1:0] IOR_RESET = 15'd12288;
  localparam logic [15:0]      ONE_Q15   = 16'h8000;
  localparam logic [60:0]      ONE_Q60   = 61'h1000_0000_0000_0000;

  // One item in flight through a square-root pipeline.
  typedef struct packed {
    logic             valid;
    logic             tir;
    logic [IOR_W-1:0] eta_i;
    logic [IOR_W-1:0] eta_t;
    logic [30:0]      ci;
    logic [60:0]      rad;   // remaining radicand
    logic [61:0]      root;
  } sq_t;

endpackage
`default_nettype wire

### rtl/core/frl_sqrt.sv
// Pipelined floor integer square root of a radicand up to 2^60, one result bit a stage.
// Depends on frl_pkg (sq_t, SQ_STEPS).
`default_nettype none
module frl_sqrt (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  frl_pkg::sq_t sq_in,
  output frl_pkg::sq_t sq_out
);
  import frl_pkg::*;

  sq_t st_r [SQ_STEPS];

  function automatic sq_t sq_step(sq_t s, int unsigned k);
    sq_t         o;
    logic [61:0] bitv;
    logic [61:0] trial;
    o     = s;
    bitv  = 62'd1 << (60 - 2 * k);
    trial = s.root + bitv;
    if ({1'b0, s.rad} >= trial) begin
      o.rad  = 61'({1'b0, s.rad} - trial);
      o.root = (s.root >> 1) + bitv;
    end else begin
      o.root = s.root >> 1;
    end
    return o;
  endfunction

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    sq_t src;
    if (k == 0) begin : g_first
      assign src = sq_in;
    end else begin : g_next
      assign src = st_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[k].valid <= 1'b0;
      end else if (en) begin
        st_r[k] <= sq_step(src, k);
      end
    end
  end

  assign sq_out = st_r[SQ_STEPS-1];

endmodule
`default_nettype wire

### rtl/core/fresnel_reflectance_top.sv
// Top level of the Fresnel reflectance pipeline.
// Depends on frl_pkg and frl_sqrt.
`default_nettype none
// Takes one request per cycle while in_stall is low and returns one result per
// request, in order, through 121 register stages; stalls at the output add to the
// time from input accept to output accept. The stages are the two square roots
// (31 stages each), the sin_t divider (30 stages) and the two reflectance ratio
// dividers (16 stages, side by side), one quotient or root bit per stage, plus 13
// stages of setup and products. The whole pipeline holds while a finished result
// is stalled at the output; in_stall is high exactly then. Write refractive_index
// only while no request is in flight.
module fresnel_reflectance_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [frl_pkg::IOR_W-1:0]  cfg_refractive_index,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [frl_pkg::COMP_W-1:0] in_incident_x,
  input  logic signed [frl_pkg::COMP_W-1:0] in_incident_y,
  input  logic signed [frl_pkg::COMP_W-1:0] in_incident_z,
  input  logic signed [frl_pkg::COMP_W-1:0] in_normal_x,
  input  logic signed [frl_pkg::COMP_W-1:0] in_normal_y,
  input  logic signed [frl_pkg::COMP_W-1:0] in_normal_z,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [15:0]                out_reflectance,
  output logic                       out_total_reflection
);
  import frl_pkg::*;

  typedef struct packed {
    logic             valid;
    logic             tir;
    logic [IOR_W-1:0] eta_i;
    logic [IOR_W-1:0] eta_t;
    logic [30:0]      ci;
    logic [45:0]      rem;
    logic [29:0]      q;
  } dv_t;

  typedef struct packed {
    logic        valid;
    logic        tir;
    logic [46:0] den1;
    logic [46:0] den2;
    logic [60:0] rem1;
    logic [60:0] rem2;
    logic [15:0] q1;
    logic [15:0] q2;
  } rt_t;

  logic en;
  logic [IOR_W-1:0] ior_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ior_r <= IOR_RESET;
    end else if (cfg_valid) begin
      ior_r <= cfg_refractive_index;
    end
  end

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // Stage 0: capture request
  logic                     v0_r;
  logic signed [COMP_W-1:0] ix_r, iy_r, iz_r, nx_r, ny_r, nz_r;
  logic [IOR_W-1:0]         ior0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ix_r   <= in_incident_x;
      iy_r   <= in_incident_y;
      iz_r   <= in_incident_z;
      nx_r   <= in_normal_x;
      ny_r   <= in_normal_y;
      nz_r   <= in_normal_z;
      ior0_r <= (ior_r == '0) ? IOR_W'(1) : ior_r;
    end
  end

  // Stage 1: component products, already Q2.30
  logic               v1_r;
  logic signed [31:0] px_r, py_r, pz_r;
  logic [IOR_W-1:0]   ior1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r   <= ix_r * nx_r;
      py_r   <= iy_r * ny_r;
      pz_r   <= iz_r * nz_r;
      ior1_r <= ior0_r;
    end
  end

  // Stage 2: dot, clamp, pick side
  logic signed [33:0] dot_sum;
  logic signed [33:0] dot_clamp;
  logic signed [33:0] dot_neg;
  localparam logic signed [33:0] ONE_Q30 = 34'sh0_4000_0000;
  logic             v2_r;
  logic [30:0]      ci2_r;
  logic [IOR_W-1:0] eta_i2_r, eta_t2_r;

  always_comb begin
    dot_sum = 34'(px_r) + 34'(py_r) + 34'(pz_r);
    if (dot_sum > ONE_Q30) begin
      dot_clamp = ONE_Q30;
    end else if (dot_sum < -ONE_Q30) begin
      dot_clamp = -ONE_Q30;
    end else begin
      dot_clamp = dot_sum;
    end
    dot_neg = -dot_clamp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  // a positive cosine means the ray leaves the surface: indices swap
  always_ff @(posedge clk) begin
    if (en) begin
      if (dot_clamp > 34'sd0) begin
        ci2_r    <= dot_clamp[30:0];
        eta_i2_r <= ior1_r;
        eta_t2_r <= ETA_ONE;
      end else begin
        ci2_r    <= dot_neg[30:0];
        eta_i2_r <= ETA_ONE;
        eta_t2_r <= ior1_r;
      end
    end
  end

  // Stage 3: ci squared
  logic             v3_r;
  logic [30:0]      ci3_r;
  logic [IOR_W-1:0] eta_i3_r, eta_t3_r;
  logic [61:0]      cisq3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ci3_r    <= ci2_r;
      eta_i3_r <= eta_i2_r;
      eta_t3_r <= eta_t2_r;
      cisq3_r  <= 62'(ci2_r) * 62'(ci2_r);
    end
  end

  // Stage 4: radicand for sin_i
  sq_t sqa_in_r, sqa_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sqa_in_r.valid <= 1'b0;
    end else if (en) begin
      sqa_in_r.valid <= v3_r;
      sqa_in_r.tir   <= 1'b0;
      sqa_in_r.eta_i <= eta_i3_r;
      sqa_in_r.eta_t <= eta_t3_r;
      sqa_in_r.ci    <= ci3_r;
      sqa_in_r.rad   <= ONE_Q60 - cisq3_r[60:0];
      sqa_in_r.root  <= '0;
    end
  end

  frl_sqrt u_sqrt_sin (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .sq_in  (sqa_in_r),
    .sq_out (sqa_out)
  );

  // Stage 5: eta_i * sin_i
  logic             v5_r;
  logic [30:0]      ci5_r;
  logic [IOR_W-1:0] eta_i5_r, eta_t5_r;
  logic [45:0]      numer5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= sqa_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ci5_r    <= sqa_out.ci;
      eta_i5_r <= sqa_out.eta_i;
      eta_t5_r <= sqa_out.eta_t;
      numer5_r <= 46'(sqa_out.eta_i) * 46'(sqa_out.root[30:0]);
    end
  end

  // Stage 6: total reflection test, divider setup
  dv_t dv_in_r;
  dv_t dv_r [DIV_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_in_r.valid <= 1'b0;
    end else if (en) begin
      dv_in_r.valid <= v5_r;
      dv_in_r.tir   <= numer5_r >= {1'b0, eta_t5_r, 30'd0};
      dv_in_r.eta_i <= eta_i5_r;
      dv_in_r.eta_t <= eta_t5_r;
      dv_in_r.ci    <= ci5_r;
      dv_in_r.rem   <= numer5_r;
      dv_in_r.q     <= '0;
    end
  end

  function automatic dv_t dv_step(dv_t s, int unsigned b);
    dv_t         o;
    logic [45:0] dsh;
    o   = s;
    dsh = 46'(s.eta_t) << b;
    if (s.rem >= dsh) begin
      o.rem  = s.rem - dsh;
      o.q[b] = 1'b1;
    end
    return o;
  endfunction

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    dv_t src;
    if (k == 0) begin : g_first
      assign src = dv_in_r;
    end else begin : g_next
      assign src = dv_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k].valid <= 1'b0;
      end else if (en) begin
        dv_r[k] <= dv_step(src, DIV_STEPS - 1 - k);
      end
    end
  end

  // Stage 7: sin_t squared
  logic             v7_r, tir7_r;
  logic [30:0]      ci7_r;
  logic [IOR_W-1:0] eta_i7_r, eta_t7_r;
  logic [59:0]      stsq7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r <= dv_r[DIV_STEPS-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tir7_r   <= dv_r[DIV_STEPS-1].tir;
      ci7_r    <= dv_r[DIV_STEPS-1].ci;
      eta_i7_r <= dv_r[DIV_STEPS-1].eta_i;
      eta_t7_r <= dv_r[DIV_STEPS-1].eta_t;
      stsq7_r  <= 60'(dv_r[DIV_STEPS-1].q) * 60'(dv_r[DIV_STEPS-1].q);
    end
  end

  // Stage 8: radicand for cos_t
  sq_t sqb_in_r, sqb_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sqb_in_r.valid <= 1'b0;
    end else if (en) begin
      sqb_in_r.valid <= v7_r;
      sqb_in_r.tir   <= tir7_r;
      sqb_in_r.eta_i <= eta_i7_r;
      sqb_in_r.eta_t <= eta_t7_r;
      sqb_in_r.ci    <= ci7_r;
      sqb_in_r.rad   <= ONE_Q60 - 61'(stsq7_r);
      sqb_in_r.root  <= '0;
    end
  end

  frl_sqrt u_sqrt_cos (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .sq_in  (sqb_in_r),
    .sq_out (sqb_out)
  );

  // Stage 9: the four index products
  logic        v9_r, tir9_r;
  logic [45:0] p1_r, q1_r, p2_r, q2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r <= 1'b0;
    end else if (en) begin
      v9_r <= sqb_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tir9_r <= sqb_out.tir;
      p1_r   <= 46'(sqb_out.eta_t) * 46'(sqb_out.ci);
      q1_r   <= 46'(sqb_out.eta_i) * 46'(sqb_out.root[30:0]);
      p2_r   <= 46'(sqb_out.eta_i) * 46'(sqb_out.ci);
      q2_r   <= 46'(sqb_out.eta_t) * 46'(sqb_out.root[30:0]);
    end
  end

  // Stage 10: ratio divider setup, |p - q| / (p + q)
  rt_t         rt_in_r;
  rt_t         rt_r [RAT_STEPS];
  logic [45:0] num1, num2;

  assign num1 = (p1_r >= q1_r) ? p1_r - q1_r : q1_r - p1_r;
  assign num2 = (p2_r >= q2_r) ? p2_r - q2_r : q2_r - p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rt_in_r.valid <= 1'b0;
    end else if (en) begin
      rt_in_r.valid <= v9_r;
      rt_in_r.tir   <= tir9_r;
      rt_in_r.den1  <= 47'(p1_r) + 47'(q1_r);
      rt_in_r.den2  <= 47'(p2_r) + 47'(q2_r);
      rt_in_r.rem1  <= {num1, 15'd0};
      rt_in_r.rem2  <= {num2, 15'd0};
      rt_in_r.q1    <= '0;
      rt_in_r.q2    <= '0;
    end
  end

  function automatic rt_t rt_step(rt_t s, int unsigned b);
    rt_t         o;
    logic [61:0] d1, d2;
    o  = s;
    d1 = 62'(s.den1) << b;
    d2 = 62'(s.den2) << b;
    if ({1'b0, s.rem1} >= d1) begin
      o.rem1  = 61'({1'b0, s.rem1} - d1);
      o.q1[b] = 1'b1;
    end
    if ({1'b0, s.rem2} >= d2) begin
      o.rem2  = 61'({1'b0, s.rem2} - d2);
      o.q2[b] = 1'b1;
    end
    return o;
  endfunction

  for (genvar k = 0; k < RAT_STEPS; k++) begin : g_rat
    rt_t src;
    if (k == 0) begin : g_first
      assign src = rt_in_r;
    end else begin : g_next
      assign src = rt_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rt_r[k].valid <= 1'b0;
      end else if (en) begin
        rt_r[k] <= rt_step(src, RAT_STEPS - 1 - k);
      end
    end
  end

  // Stage 11: square the ratios; a zero denominator counts as 1.0
  logic        v11_r, tir11_r;
  logic [31:0] rsq1_r, rsq2_r;
  logic [15:0] r1, r2;

  assign r1 = (rt_r[RAT_STEPS-1].den1 == '0) ? ONE_Q15 : rt_r[RAT_STEPS-1].q1;
  assign r2 = (rt_r[RAT_STEPS-1].den2 == '0) ? ONE_Q15 : rt_r[RAT_STEPS-1].q2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v11_r <= 1'b0;
    end else if (en) begin
      v11_r <= rt_r[RAT_STEPS-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tir11_r <= rt_r[RAT_STEPS-1].tir;
      rsq1_r  <= r1 * r1;
      rsq2_r  <= r2 * r2;
    end
  end

  // Stage 12: average, saturate, force 1.0 on total reflection, output register
  logic [32:0] kr_sum;
  logic [15:0] kr_nxt;
  logic        out_valid_r, out_tir_r;
  logic [15:0] out_kr_r;

  assign kr_sum = 33'(rsq1_r) + 33'(rsq2_r);
  assign kr_nxt = (kr_sum[32:16] > 17'(ONE_Q15)) ? ONE_Q15 : kr_sum[31:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v11_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tir_r <= tir11_r;
      out_kr_r  <= tir11_r ? ONE_Q15 : kr_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_reflectance      = out_kr_r;
  assign out_total_reflection = out_tir_r;

  a_tir_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_total_reflection |-> out_reflectance == ONE_Q15)
    else $error("total reflection without full reflectance");

  a_kr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_reflectance <= ONE_Q15)
    else $error("reflectance above 1.0");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

  a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(v11_r) && $stable(rt_in_r.valid))
    else $error("pipeline moved during stall");

endmodule
`default_nettype wire
